>>> rtl/teaching_cpu_instruction_step_defines.svh
// assertion macros shared by the teaching cpu rtl
`ifndef TEACHING_CPU_INSTRUCTION_STEP_DEFINES_SVH
`define TEACHING_CPU_INSTRUCTION_STEP_DEFINES_SVH

// checked only outside reset
`define TCPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define TCPU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/tcpu_pkg.sv
// shared types, constants and functions of the teaching cpu
`timescale 1ns / 1ps
package tcpu_pkg;

  localparam int unsigned TcpuMemBytes = 65536;
  localparam int unsigned NumRegs      = 8;
  localparam int unsigned RegIdxW      = 3;
  localparam int unsigned WordW        = 32;
  localparam int unsigned PcW          = 16;
  localparam int unsigned CfgAddrW     = 3;

  typedef enum logic [1:0] {
    KIND_WRB    = 2'd0,
    KIND_EXEC   = 2'd1,
    KIND_RDREG  = 2'd2,
    KIND_RDWORD = 2'd3
  } kind_e;

  // opcodes
  localparam logic [3:0] OP_LDI = 4'h0;
  localparam logic [3:0] OP_LDO = 4'h1;
  localparam logic [3:0] OP_LDX = 4'h2;
  localparam logic [3:0] OP_STO = 4'h3;
  localparam logic [3:0] OP_STX = 4'h4;
  localparam logic [3:0] OP_ALU = 4'h6;
  localparam logic [3:0] OP_SHF = 4'h7;
  localparam logic [3:0] OP_BR  = 4'h8;
  localparam logic [3:0] OP_BEQ = 4'h9;
  localparam logic [3:0] OP_BGT = 4'ha;
  localparam logic [3:0] OP_J   = 4'hb;
  localparam logic [3:0] OP_JI  = 4'hc;
  localparam logic [3:0] OP_SYS = 4'hf;

  // alu functions
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_ADD  = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_INC  = 4'h3;
  localparam logic [3:0] ALU_INCA = 4'h4;
  localparam logic [3:0] ALU_DEC  = 4'h5;
  localparam logic [3:0] ALU_DECA = 4'h6;
  localparam logic [3:0] ALU_NOT  = 4'h7;
  localparam logic [3:0] ALU_GPC  = 4'hf;

  localparam logic [3:0] SYS_HALT = 4'h0;

  typedef enum logic [1:0] {
    WS_INPUT = 2'd0,
    WS_INSTR = 2'd1,
    WS_CFG   = 2'd2
  } wrap_sel_e;

  typedef enum logic [1:0] {
    RFA_IN = 2'd0,
    RFA_A  = 2'd1,
    RFA_C  = 2'd2
  } rfa_sel_e;

  typedef enum logic {
    BASE_PC   = 1'b0,
    BASE_WRAP = 1'b1
  } base_sel_e;

  typedef struct packed {
    logic      in_ready;
    logic      clr_wr;
    logic      wrap_start;
    wrap_sel_e wrap_sel;
    logic      mem_start;
    logic      mem_wr;
    logic      mem_len4;
    base_sel_e base_sel;
    logic      ir_load;
    logic      imm_load;
    logic      opab_load;
    logic      opc_load;
    rfa_sel_e  rfa_sel;
    logic      exec;
    logic      reg_load_word;
    logic      pc_load_wrap;
    logic      pc_fix;
    logic      byte_wr_in;
    logic      out_load;
  } tcpu_cmd_t;

  typedef struct packed {
    logic  in_valid;
    kind_e kind;
    logic  halted;
    logic  pc_fix_pending;
    logic  clr_last;
    logic  wrap_busy;
    logic  eng_busy;
    logic  long_instr;
    logic  need_wrap;
    logic  mem_op;
    logic  is_store;
    logic  out_free;
  } tcpu_status_t;

  // left by s for s in 1..127, otherwise arithmetic right by -s
  function automatic logic [WordW-1:0] shift_signed(input logic [WordW-1:0] v,
                                                    input logic [7:0] s);
    logic [7:0] n;
    logic [WordW-1:0] res;
    n = 8'(8'd0 - s);
    if (s >= 8'd1 && s <= 8'd127) begin
      res = (s >= 8'd32) ? '0 : (v << s[4:0]);
    end else if (n >= 8'd32 || s == 8'd128) begin
      res = {WordW{v[WordW-1]}};
    end else begin
      res = WordW'($signed(v) >>> n[4:0]);
    end
    return res;
  endfunction

endpackage

>>> rtl/tcpu_if.sv
// valid/ready channel interfaces for the teaching cpu
`timescale 1ns / 1ps
interface tcpu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] address;
  logic [7:0]  data;
  modport source (output valid, kind, address, data, input ready);
  modport sink (input valid, kind, address, data, output ready);
endinterface

interface tcpu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic [15:0] program_counter;
  logic        halted;
  logic        illegal;
  modport source (output valid, read_value, program_counter, halted, illegal, input ready);
  modport sink (input valid, read_value, program_counter, halted, illegal, output ready);
endinterface

>>> rtl/tcpu_wrap.sv
// reduces a 32-bit value modulo the memory size
`timescale 1ns / 1ps
module tcpu_wrap import tcpu_pkg::*; #(
  parameter int unsigned MEM_BYTES = TcpuMemBytes
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [WordW-1:0]             value_i,
  output logic                         busy_o,
  output logic [$clog2(MEM_BYTES)-1:0] rem_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam bit IsPow2 = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);

  logic [AW-1:0] rem_q;
  assign rem_o = rem_q;

  if (IsPow2) begin : g_mask
    assign busy_o = 1'b0;
    always_ff @(posedge clk_i) begin
      if (start_i) rem_q <= value_i[AW-1:0];
    end
  end else begin : g_recip
    // quotient estimate by reciprocal multiply, low by at most one,
    // then multiply-subtract and one conditional subtract, each step registered
    localparam logic [WordW-1:0] Recip = WordW'(64'h1_0000_0000 / 64'(MEM_BYTES));
    localparam logic [WordW-1:0] MemW  = WordW'(MEM_BYTES);
    logic [WordW-1:0]   x_q, q_q, r_q;
    logic [2*WordW-1:0] prod;
    logic [WordW-1:0]   r1;
    logic [1:0]         cnt_q;
    logic               busy_q;

    assign busy_o = busy_q;
    assign prod   = x_q * Recip;
    assign r1     = (r_q >= MemW) ? (r_q - MemW) : r_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        cnt_q  <= '0;
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd3;
      end else if (busy_q) begin
        busy_q <= (cnt_q != 2'd1);
        cnt_q  <= cnt_q - 2'd1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        x_q <= value_i;
      end else if (busy_q) begin
        q_q   <= prod[2*WordW-1:WordW];
        r_q   <= x_q - q_q * MemW;
        rem_q <= r1[AW-1:0];
      end
    end
  end

endmodule

>>> rtl/tcpu_dp.sv
// datapath: memory, register file, byte engine, pc and result register
`timescale 1ns / 1ps
module tcpu_dp import tcpu_pkg::*; #(
  parameter int unsigned MEM_BYTES = TcpuMemBytes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcpu_cmd_t          cmd_i,
  output tcpu_status_t       status_o,
  input  logic               in_valid_i,
  input  logic [1:0]         in_kind_i,
  input  logic [15:0]        in_address_i,
  input  logic [7:0]         in_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [WordW-1:0]   out_read_value_o,
  output logic [PcW-1:0]     out_pc_o,
  output logic               out_halted_o,
  output logic               out_illegal_o,
  input  logic               cfg_we_i,
  input  logic [PcW-1:0]     cfg_wdata_i,
  output logic [PcW-1:0]     start_pc_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [AW:0]   MemTop  = (AW+1)'(MEM_BYTES);
  localparam logic [AW-1:0] MemLast = AW'(MEM_BYTES - 1);

  function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] p, input logic [2:0] k);
    logic [AW:0] t;
    t = {1'b0, p} + (AW+1)'(k);
    if (t >= MemTop) t = t - MemTop;
    return t[AW-1:0];
  endfunction

  logic accept;
  assign accept = cmd_i.in_ready & in_valid_i;

  // input item
  kind_e       kind_q;
  logic [15:0] in_addr_q;
  logic [7:0]  in_data_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= kind_e'(in_kind_i);
      in_addr_q <= in_address_i;
      in_data_q <= in_data_i;
    end
  end

  // architectural control state
  logic [PcW-1:0] start_pc_q;
  logic           pc_fix_q;
  logic [AW-1:0]  pc_q;
  logic           halted_q;
  logic           illegal_q;
  logic [AW-1:0]  rem;
  logic           wrap_busy;
  logic           ill_set;
  logic           halt_set;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pc_q <= '0;
      pc_fix_q   <= 1'b0;
      pc_q       <= '0;
      halted_q   <= 1'b0;
      illegal_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        start_pc_q <= cfg_wdata_i;
        pc_fix_q   <= 1'b1;
      end else if (cmd_i.pc_fix) begin
        pc_fix_q <= 1'b0;
      end
      if (cmd_i.pc_fix || cmd_i.pc_load_wrap) pc_q <= rem;
      else if (cmd_i.ir_load) pc_q <= add_wrap(pc_q, 3'd2);
      else if (cmd_i.imm_load) pc_q <= add_wrap(pc_q, 3'd4);
      if (halt_set) halted_q <= 1'b1;
      if (accept) illegal_q <= 1'b0;
      else if (ill_set) illegal_q <= 1'b1;
    end
  end
  assign start_pc_o = start_pc_q;

  // instruction fields
  logic [15:0]      ir_q;
  logic [WordW-1:0] imm_q, opa_q, opb_q, opc_q, word_q;
  logic [3:0]       op, na, nb;
  logic [7:0]       sbyte;
  logic [RegIdxW-1:0] ra, rb, rc;
  assign op    = ir_q[15:12];
  assign na    = ir_q[11:8];
  assign nb    = ir_q[7:4];
  assign sbyte = ir_q[7:0];
  assign ra    = na[RegIdxW-1:0];
  assign rb    = nb[RegIdxW-1:0];
  assign rc    = ir_q[RegIdxW-1:0];

  // register file, two registered read ports
  logic [WordW-1:0]   rf_q [NumRegs];
  logic [NumRegs-1:0] rf_vld_q;
  logic [WordW-1:0]   rda_q, rdb_q;
  logic [RegIdxW-1:0] rda_addr;
  logic               rf_we;
  logic [RegIdxW-1:0] rf_waddr;
  logic [WordW-1:0]   rf_wdata;

  always_comb begin
    case (cmd_i.rfa_sel)
      RFA_A:   rda_addr = ra;
      RFA_C:   rda_addr = rc;
      default: rda_addr = in_addr_q[RegIdxW-1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rf_vld_q <= '0;
    else if (rf_we) rf_vld_q[rf_waddr] <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_q[rf_waddr] <= rf_wdata;
    rda_q <= rf_vld_q[rda_addr] ? rf_q[rda_addr] : '0;
    rdb_q <= rf_vld_q[rb] ? rf_q[rb] : '0;
    if (cmd_i.ir_load) ir_q <= word_q[15:0];
    if (cmd_i.imm_load) imm_q <= word_q;
    if (cmd_i.opab_load) begin
      opa_q <= rda_q;
      opb_q <= rdb_q;
    end
    if (cmd_i.opc_load) opc_q <= rda_q;
  end

  // branch decision and address sources
  logic             taken;
  logic [WordW-1:0] rel_tgt, wrap_val;
  always_comb begin
    case (op)
      OP_BR:   taken = 1'b1;
      OP_BEQ:  taken = (opa_q == '0);
      OP_BGT:  taken = (opa_q != '0) && !opa_q[WordW-1];
      default: taken = 1'b0;
    endcase
  end
  assign rel_tgt = WordW'(pc_q) + {{(WordW-9){sbyte[7]}}, sbyte, 1'b0};

  always_comb begin
    case (cmd_i.wrap_sel)
      WS_CFG:   wrap_val = WordW'(start_pc_q);
      WS_INSTR: begin
        case (op)
          OP_LDO:  wrap_val = {26'd0, na, 2'b00} + opb_q;
          OP_LDX:  wrap_val = opa_q + {opb_q[WordW-3:0], 2'b00};
          OP_STO:  wrap_val = {26'd0, nb, 2'b00} + opc_q;
          OP_STX:  wrap_val = opb_q + {opc_q[WordW-3:0], 2'b00};
          OP_J:    wrap_val = imm_q;
          OP_JI:   wrap_val = {23'd0, sbyte, 1'b0} + opa_q;
          default: wrap_val = rel_tgt;
        endcase
      end
      default:  wrap_val = WordW'(in_addr_q);
    endcase
  end

  tcpu_wrap #(.MEM_BYTES(MEM_BYTES)) u_wrap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.wrap_start),
    .value_i (wrap_val),
    .busy_o  (wrap_busy),
    .rem_o   (rem)
  );

  // execute stage for register-only instructions and the write-back of loaded words
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = rc;
    rf_wdata = word_q;
    ill_set  = 1'b0;
    halt_set = 1'b0;
    if (cmd_i.reg_load_word) begin
      rf_we = 1'b1;
    end else if (cmd_i.exec) begin
      case (op)
        OP_LDI: begin
          rf_we    = 1'b1;
          rf_waddr = ra;
          rf_wdata = imm_q;
        end
        OP_SHF: begin
          rf_we    = 1'b1;
          rf_waddr = ra;
          rf_wdata = shift_signed(opa_q, sbyte);
        end
        OP_ALU: begin
          rf_we = 1'b1;
          case (na)
            ALU_MOV:  rf_wdata = opb_q;
            ALU_ADD:  rf_wdata = opb_q + opc_q;
            ALU_AND:  rf_wdata = opb_q & opc_q;
            ALU_INC:  rf_wdata = opc_q + 32'd1;
            ALU_INCA: rf_wdata = opc_q + 32'd4;
            ALU_DEC:  rf_wdata = opc_q - 32'd1;
            ALU_DECA: rf_wdata = opc_q - 32'd4;
            ALU_NOT:  rf_wdata = ~opc_q;
            ALU_GPC:  rf_wdata = WordW'(pc_q) + {27'd0, nb, 1'b0};
            default: begin
              rf_we   = 1'b0;
              ill_set = 1'b1;
            end
          endcase
        end
        OP_SYS: halt_set = (na == SYS_HALT);
        default: ill_set = !(op inside {OP_LDO, OP_LDX, OP_STO, OP_STX,
                                        OP_BR, OP_BEQ, OP_BGT, OP_J, OP_JI});
      endcase
    end
  end

  // byte engine: streams up to four big-endian bytes through the memory port
  logic               eng_busy_q, eng_wr_q, eng_rvld_q;
  logic [2:0]         eng_issue_q, eng_recv_q;
  logic [AW-1:0]      eng_ptr_q, clr_ptr_q;
  logic [WordW-1:0]   st_q;
  logic               eng_issue, eng_dec;
  logic [2:0]         recv_n;
  logic [7:0]         mem_q [MEM_BYTES];
  logic [7:0]         mem_rdata_q, mem_wdata;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;

  assign eng_issue = eng_busy_q && (eng_issue_q != 3'd0);
  assign eng_dec   = eng_wr_q ? eng_issue : eng_rvld_q;
  assign recv_n    = eng_recv_q - 3'(eng_dec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_busy_q  <= 1'b0;
      eng_wr_q    <= 1'b0;
      eng_rvld_q  <= 1'b0;
      eng_issue_q <= '0;
      eng_recv_q  <= '0;
      clr_ptr_q   <= '0;
    end else begin
      eng_rvld_q <= eng_issue && !eng_wr_q;
      if (cmd_i.mem_start) begin
        eng_busy_q  <= 1'b1;
        eng_wr_q    <= cmd_i.mem_wr;
        eng_issue_q <= cmd_i.mem_len4 ? 3'd4 : 3'd2;
        eng_recv_q  <= cmd_i.mem_len4 ? 3'd4 : 3'd2;
      end else if (eng_busy_q) begin
        if (eng_issue) eng_issue_q <= eng_issue_q - 3'd1;
        eng_recv_q <= recv_n;
        eng_busy_q <= (recv_n != 3'd0);
      end
      if (cmd_i.clr_wr) clr_ptr_q <= add_wrap(clr_ptr_q, 3'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_start) begin
      eng_ptr_q <= (cmd_i.base_sel == BASE_WRAP) ? rem : pc_q;
      st_q      <= rda_q;
    end else if (eng_issue) begin
      eng_ptr_q <= add_wrap(eng_ptr_q, 3'd1);
      st_q      <= {st_q[WordW-9:0], 8'd0};
    end
    if (eng_rvld_q) word_q <= {word_q[WordW-9:0], mem_rdata_q};
  end

  // single memory port
  always_comb begin
    mem_addr  = eng_ptr_q;
    mem_we    = eng_issue && eng_wr_q;
    mem_wdata = st_q[WordW-1:WordW-8];
    if (cmd_i.clr_wr) begin
      mem_addr  = clr_ptr_q;
      mem_we    = 1'b1;
      mem_wdata = 8'd0;
    end else if (cmd_i.byte_wr_in) begin
      mem_addr  = rem;
      mem_we    = 1'b1;
      mem_wdata = in_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    mem_rdata_q <= mem_q[mem_addr];
  end

  // result register
  logic             out_valid_q;
  logic [WordW-1:0] out_val_q;
  logic [PcW-1:0]   out_pc_q;
  logic             out_halt_q, out_ill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (kind_q)
        KIND_RDREG:  out_val_q <= rda_q;
        KIND_RDWORD: out_val_q <= word_q;
        default:     out_val_q <= '0;
      endcase
      out_pc_q   <= PcW'(pc_q);
      out_halt_q <= halted_q;
      out_ill_q  <= illegal_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_read_value_o = out_val_q;
  assign out_pc_o         = out_pc_q;
  assign out_halted_o     = out_halt_q;
  assign out_illegal_o    = out_ill_q;

  // status toward the controller
  always_comb begin
    status_o.in_valid       = in_valid_i;
    status_o.kind           = kind_q;
    status_o.halted         = halted_q;
    status_o.pc_fix_pending = pc_fix_q;
    status_o.clr_last       = (clr_ptr_q == MemLast);
    status_o.wrap_busy      = wrap_busy;
    status_o.eng_busy       = eng_busy_q;
    status_o.long_instr     = (op == OP_LDI) || (op == OP_J);
    status_o.mem_op         = op inside {OP_LDO, OP_LDX, OP_STO, OP_STX};
    status_o.is_store       = op inside {OP_STO, OP_STX};
    status_o.need_wrap      = (op inside {OP_LDO, OP_LDX, OP_STO, OP_STX, OP_J, OP_JI})
                              || taken;
    status_o.out_free       = !out_valid_q || out_ready_i;
  end

endmodule

>>> rtl/tcpu_ctrl.sv
// sequencing state machine of the teaching cpu
`timescale 1ns / 1ps
module tcpu_ctrl import tcpu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tcpu_status_t status_i,
  output tcpu_cmd_t    cmd_o
);

  typedef enum logic [15:0] {
    S_CLEAR      = 16'h0001,
    S_IDLE       = 16'h0002,
    S_PCFIX      = 16'h0004,
    S_DISPATCH   = 16'h0008,
    S_IN_WAIT    = 16'h0010,
    S_RD_WAIT    = 16'h0020,
    S_FETCH_WAIT = 16'h0040,
    S_IMM_GO     = 16'h0080,
    S_IMM_WAIT   = 16'h0100,
    S_OPS1       = 16'h0200,
    S_OPS2       = 16'h0400,
    S_OPS3       = 16'h0800,
    S_DECODE     = 16'h1000,
    S_WRAP_WAIT  = 16'h2000,
    S_MEM_WAIT   = 16'h4000,
    S_DONE       = 16'h8000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  always_comb begin
    cmd_o    = '0;
    cmd_o.wrap_sel = WS_INPUT;
    cmd_o.rfa_sel  = RFA_IN;
    cmd_o.base_sel = BASE_PC;
    state_d  = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (status_i.pc_fix_pending) begin
          cmd_o.wrap_start = 1'b1;
          cmd_o.wrap_sel   = WS_CFG;
          state_d          = S_PCFIX;
        end else begin
          cmd_o.in_ready = 1'b1;
          if (status_i.in_valid) state_d = S_DISPATCH;
        end
      end
      S_PCFIX: begin
        if (!status_i.wrap_busy) begin
          cmd_o.pc_fix = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DISPATCH: begin
        case (status_i.kind)
          KIND_WRB, KIND_RDWORD: begin
            cmd_o.wrap_start = 1'b1;
            state_d          = S_IN_WAIT;
          end
          KIND_EXEC: begin
            if (status_i.halted) begin
              state_d = S_DONE;
            end else begin
              cmd_o.mem_start = 1'b1;
              state_d         = S_FETCH_WAIT;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_IN_WAIT: begin
        if (!status_i.wrap_busy) begin
          if (status_i.kind == KIND_WRB) begin
            cmd_o.byte_wr_in = 1'b1;
            state_d          = S_DONE;
          end else begin
            cmd_o.mem_start = 1'b1;
            cmd_o.mem_len4  = 1'b1;
            cmd_o.base_sel  = BASE_WRAP;
            state_d         = S_RD_WAIT;
          end
        end
      end
      S_RD_WAIT: begin
        if (!status_i.eng_busy) state_d = S_DONE;
      end
      S_FETCH_WAIT: begin
        if (!status_i.eng_busy) begin
          cmd_o.ir_load = 1'b1;
          state_d       = S_IMM_GO;
        end
      end
      S_IMM_GO: begin
        if (status_i.long_instr) begin
          cmd_o.mem_start = 1'b1;
          cmd_o.mem_len4  = 1'b1;
          state_d         = S_IMM_WAIT;
        end else begin
          state_d = S_OPS1;
        end
      end
      S_IMM_WAIT: begin
        if (!status_i.eng_busy) begin
          cmd_o.imm_load = 1'b1;
          state_d        = S_OPS1;
        end
      end
      S_OPS1: begin
        cmd_o.rfa_sel = RFA_A;
        state_d       = S_OPS2;
      end
      S_OPS2: begin
        cmd_o.opab_load = 1'b1;
        cmd_o.rfa_sel   = RFA_C;
        state_d         = S_OPS3;
      end
      S_OPS3: begin
        cmd_o.opc_load = 1'b1;
        cmd_o.rfa_sel  = RFA_A;
        state_d        = S_DECODE;
      end
      S_DECODE: begin
        cmd_o.rfa_sel = RFA_A;
        if (status_i.need_wrap) begin
          cmd_o.wrap_start = 1'b1;
          cmd_o.wrap_sel   = WS_INSTR;
          state_d          = S_WRAP_WAIT;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = S_DONE;
        end
      end
      S_WRAP_WAIT: begin
        // store data comes from port a, still pointing at ra
        cmd_o.wrap_sel = WS_INSTR;
        cmd_o.rfa_sel  = RFA_A;
        if (!status_i.wrap_busy) begin
          if (status_i.mem_op) begin
            cmd_o.mem_start = 1'b1;
            cmd_o.mem_len4  = 1'b1;
            cmd_o.mem_wr    = status_i.is_store;
            cmd_o.base_sel  = BASE_WRAP;
            state_d         = S_MEM_WAIT;
          end else begin
            cmd_o.pc_load_wrap = 1'b1;
            state_d            = S_DONE;
          end
        end
      end
      S_MEM_WAIT: begin
        if (!status_i.eng_busy) begin
          cmd_o.reg_load_word = !status_i.is_store;
          state_d             = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

>>> rtl/teaching_cpu_instruction_step.sv
// top level of the teaching cpu: channels, configuration port and checks
`timescale 1ns / 1ps
`include "teaching_cpu_instruction_step_defines.svh"
// usage
//   in_if carries one beat per item: kind 0 writes a memory byte, 1 executes one
//   instruction, 2 reads a register, 3 reads a big-endian memory word
//   out_if returns exactly one beat per item with the read value, the pc after
//   the item, the halted flag and the illegal flag of that step
//   start_pc sits at apb address 0; writing it also reloads the pc
// sequencing
//   one item at a time; an execute takes a two-byte fetch, a four-byte immediate
//   for ldi and j, three register reads and up to four data bytes, all bytes
//   through one memory port; when the memory size is not a power of two every
//   address reduction passes through the reciprocal remainder unit
// reset
//   the memory is zeroed by a sweep over all MEM_BYTES bytes, one byte per cycle;
//   no input beat is taken until it finishes, apb writes are taken as ever
// back pressure
//   a finished result waits in the output register; the next input beat is
//   taken meanwhile, and its result waits until the register drains
module teaching_cpu_instruction_step import tcpu_pkg::*; #(
  parameter int unsigned MEM_BYTES = TcpuMemBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tcpu_in_if.sink             in_if,
  tcpu_out_if.source          out_if,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [CfgAddrW-1:0] paddr_i,
  input  logic [31:0]         pwdata_i,
  output logic [31:0]         prdata_o,
  output logic                pready_o
);

  tcpu_cmd_t      cmd;
  tcpu_status_t   status;
  logic           cfg_we;
  logic [PcW-1:0] start_pc;

  // only start_pc exists; paddr bit 2 set means beyond the register list
  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && !paddr_i[2];
  assign prdata_o = paddr_i[2] ? 32'd0 : 32'(start_pc);

  assign in_if.ready = cmd.in_ready;

  tcpu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tcpu_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .in_valid_i       (in_if.valid),
    .in_kind_i        (in_if.kind),
    .in_address_i     (in_if.address),
    .in_data_i        (in_if.data),
    .out_ready_i      (out_if.ready),
    .out_valid_o      (out_if.valid),
    .out_read_value_o (out_if.read_value),
    .out_pc_o         (out_if.program_counter),
    .out_halted_o     (out_if.halted),
    .out_illegal_o    (out_if.illegal),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (pwdata_i[PcW-1:0]),
    .start_pc_o       (start_pc)
  );

  // checks
  `TCPU_ASSERT_ALWAYS(a_no_accept_in_reset, !rst_ni |-> !in_if.ready, "input taken in reset")
  `TCPU_ASSERT(a_one_item_at_a_time, (in_if.valid && in_if.ready) |=> !in_if.ready, "second beat taken while busy")
  `TCPU_ASSERT(a_no_result_overwrite, cmd.out_load |-> (!out_if.valid || out_if.ready), "result register overwritten")
  `TCPU_ASSERT(a_halt_sticky, !$fell(status.halted), "halted flag cleared")
  `TCPU_ASSERT(a_pc_in_memory, out_if.valid |-> (32'(out_if.program_counter) < MEM_BYTES), "pc beyond memory")

endmodule

>>> tb/tcpu_step_checker.sv
// checker for the teaching cpu: watches both channels and the apb port, predicts and compares
`timescale 1ns / 1ps
module tcpu_step_checker import tcpu_pkg::*; #(
  parameter logic [CfgAddrW-1:0] StartPcAddr = '0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tcpu_in_if                  in_ch,
  tcpu_out_if                 out_ch,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [CfgAddrW-1:0] paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic                pready_i,
  output int                  errors_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [31:0] value;
    logic [15:0] pc;
    logic        halted;
    logic        illegal;
  } cpu_result_t;

  logic [7:0]  mem_img [0:65535];
  logic [31:0] gpr [0:7];
  logic [15:0] pc_q;
  logic        halt_q;
  cpu_result_t result_q [$];

  function automatic logic [31:0] word_at(input logic [31:0] a);
    return {mem_img[a[15:0]], mem_img[16'(a + 1)], mem_img[16'(a + 2)], mem_img[16'(a + 3)]};
  endfunction

  task automatic word_put(input logic [31:0] a, input logic [31:0] v);
    mem_img[a[15:0]]    = v[31:24];
    mem_img[16'(a + 1)] = v[23:16];
    mem_img[16'(a + 2)] = v[15:8];
    mem_img[16'(a + 3)] = v[7:0];
  endtask

  // positive byte shifts left, the rest shift right arithmetically by the negated byte
  function automatic logic [31:0] shift_by(input logic [31:0] v, input logic [7:0] s);
    logic [7:0] n;
    n = 8'(8'd0 - s);
    if (s >= 8'd1 && s <= 8'd127) return (s >= 8'd32) ? 32'h0 : (v << s);
    if (n == 8'd0) return v;
    if (n >= 8'd32) return {32{v[31]}};
    return 32'($signed(v) >>> n);
  endfunction

  task automatic run_instr(output logic bad);
    logic [7:0]  b0, b1;
    logic [3:0]  op, na, nb, nc;
    logic [2:0]  ra, rb, rc;
    logic [31:0] rel, imm;
    logic [15:0] npc;
    b0 = mem_img[pc_q];
    b1 = mem_img[16'(pc_q + 1)];
    op = b0[7:4]; na = b0[3:0]; nb = b1[7:4]; nc = b1[3:0];
    ra = na[2:0]; rb = nb[2:0]; rc = nc[2:0];
    rel = {{23{b1[7]}}, b1, 1'b0};
    imm = '0;
    bad = 1'b0;
    npc = 16'(pc_q + 2);
    if (op == OP_LDI || op == OP_J) begin
      imm = word_at({16'h0, npc});
      npc = 16'(npc + 4);
    end
    case (op)
      OP_LDI: gpr[ra] = imm;
      OP_LDO: gpr[rc] = word_at({26'h0, na, 2'b00} + gpr[rb]);
      OP_LDX: gpr[rc] = word_at(gpr[ra] + (gpr[rb] << 2));
      OP_STO: word_put({26'h0, nb, 2'b00} + gpr[rc], gpr[ra]);
      OP_STX: word_put(gpr[rb] + (gpr[rc] << 2), gpr[ra]);
      OP_ALU: begin
        case (na)
          ALU_MOV:  gpr[rc] = gpr[rb];
          ALU_ADD:  gpr[rc] = gpr[rb] + gpr[rc];
          ALU_AND:  gpr[rc] = gpr[rb] & gpr[rc];
          ALU_INC:  gpr[rc] = gpr[rc] + 32'd1;
          ALU_INCA: gpr[rc] = gpr[rc] + 32'd4;
          ALU_DEC:  gpr[rc] = gpr[rc] - 32'd1;
          ALU_DECA: gpr[rc] = gpr[rc] - 32'd4;
          ALU_NOT:  gpr[rc] = ~gpr[rc];
          ALU_GPC:  gpr[rc] = {16'h0, npc} + {27'h0, nb, 1'b0};
          default:  bad = 1'b1;
        endcase
      end
      OP_SHF: gpr[ra] = shift_by(gpr[ra], b1);
      OP_BR:  npc = 16'(npc + rel);
      OP_BEQ: if (gpr[ra] == 32'h0) npc = 16'(npc + rel);
      OP_BGT: if (gpr[ra] != 32'h0 && !gpr[ra][31]) npc = 16'(npc + rel);
      OP_J:   npc = imm[15:0];
      OP_JI:  npc = 16'({23'h0, b1, 1'b0} + gpr[ra]);
      OP_SYS: if (na == SYS_HALT) halt_q = 1'b1;
      default: bad = 1'b1;
    endcase
    pc_q = npc;
  endtask

  task automatic step_cpu(input logic [1:0] k, input logic [15:0] a, input logic [7:0] d,
                          output cpu_result_t r);
    logic bad;
    bad = 1'b0;
    r.value = '0;
    case (kind_e'(k))
      KIND_WRB:    mem_img[a] = d;
      KIND_EXEC:   if (!halt_q) run_instr(bad);
      KIND_RDREG:  r.value = gpr[a[2:0]];
      KIND_RDWORD: r.value = word_at({16'h0, a});
      default:     ;
    endcase
    r.pc      = pc_q;
    r.halted  = halt_q;
    r.illegal = bad;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : model
    cpu_result_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < 65536; i++) mem_img[i] = 8'h00;
      for (int i = 0; i < 8; i++) gpr[i] = 32'h0;
      pc_q      = 16'h0;
      halt_q    = 1'b0;
      result_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == StartPcAddr)
        pc_q = pwdata_i[15:0];
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.read_value, out_ch.program_counter, out_ch.halted, out_ch.illegal};
        if (result_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("result beat with none expected: value %h pc %h halted %b illegal %b",
                     got.value, got.pc, got.halted, got.illegal);
        end else begin
          want = result_q.pop_front();
          if (got.value !== want.value || got.pc !== want.pc ||
              got.halted !== want.halted || got.illegal !== want.illegal) begin
            errors_o++;
            if (errors_o <= 10)
              $display("mismatch: expected value %h pc %h halted %b illegal %b, got %h %h %b %b",
                       want.value, want.pc, want.halted, want.illegal,
                       got.value, got.pc, got.halted, got.illegal);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        step_cpu(in_ch.kind, in_ch.address, in_ch.data, want);
        result_q.push_back(want);
      end
      pending_o = result_q.size();
    end
  end

endmodule

>>> tb/tb.sv
// testbench top for the teaching cpu: clock, reset, stimulus, back pressure and verdict
`timescale 1ns / 1ps
module tb import tcpu_pkg::*;;

  localparam logic [CfgAddrW-1:0] StartPcAddr = '0;
  // the memory sweep after reset runs with no beat, so the limit must outlast it
  localparam int StallLimit = 200000;
  localparam int ItemTarget = 1450;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel_q = 1'b0;
  logic penable_q = 1'b0;
  logic pwrite_q = 1'b0;
  logic [CfgAddrW-1:0] paddr_q = '0;
  logic [31:0] pwdata_q = '0;
  logic [31:0] prdata;
  logic pready;

  int beats_in = 0;
  int beats_out = 0;
  int still_cycles = 0;
  int send_idle = 21;
  int recv_idle = 71;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int errors, pending;

  tcpu_in_if  in_if ();
  tcpu_out_if out_if ();

  teaching_cpu_instruction_step uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_if),
    .out_if    (out_if),
    .psel_i    (psel_q),
    .penable_i (penable_q),
    .pwrite_i  (pwrite_q),
    .paddr_i   (paddr_q),
    .pwdata_i  (pwdata_q),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  tcpu_step_checker #(.StartPcAddr(StartPcAddr)) checker_i (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .psel_i    (psel_q),
    .penable_i (penable_q),
    .pwrite_i  (pwrite_q),
    .paddr_i   (paddr_q),
    .pwdata_i  (pwdata_q),
    .pready_i  (pready),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #1 clk_i = ~clk_i;

  // beat counters on both channels
  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) beats_in <= beats_in + 1;
    if (out_if.valid && out_if.ready) beats_out <= beats_out + 1;
  end

  // watchdog: ends the run after a long stretch with no beat on either side
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      still_cycles <= 0;
    end else begin
      still_cycles <= still_cycles + 1;
      if (still_cycles >= StallLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off so the block backs up its input
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_out >= 400) begin
      out_if.ready <= 1'b0;
      hold_left <= 150;
      hold_done <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // offer one item, with random gaps first; returns at the accepting edge
  task automatic put_item(input kind_e k, input logic [15:0] a, input logic [7:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.kind    <= k;
    in_if.address <= a;
    in_if.data    <= d;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // drop valid and wait until every accepted item has its result
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (beats_out != beats_in) @(posedge clk_i);
  endtask

  // start_pc write: setup then access, the register takes it at the access edge
  task automatic set_start_pc(input logic [15:0] v);
    psel_q    <= 1'b1;
    penable_q <= 1'b0;
    pwrite_q  <= 1'b1;
    paddr_q   <= StartPcAddr;
    pwdata_q  <= {16'h0, v};
    @(posedge clk_i);
    penable_q <= 1'b1;
    @(posedge clk_i);
    psel_q    <= 1'b0;
    penable_q <= 1'b0;
  endtask

  // lay down random instructions from base, lengths matching their opcodes, halt kept out
  task automatic load_program(input logic [15:0] base, input int count);
    logic [7:0]  code [0:5];
    logic [3:0]  op, fn;
    logic [31:0] imm;
    logic [15:0] at;
    int len;
    at = base;
    for (int n = 0; n < count; n++) begin
      op = 4'($urandom_range(15));
      fn = 4'($urandom_range(15));
      if (op == OP_SYS && fn == SYS_HALT) fn = 4'h1;
      case ($urandom_range(3))
        0: imm = 32'($urandom_range(511));
        1: imm = 32'h8000_0000;
        2: imm = 32'hffff_ffff - 32'($urandom_range(3));
        default: imm = $urandom();
      endcase
      code[0] = {op, fn};
      code[1] = 8'($urandom_range(255));
      {code[2], code[3], code[4], code[5]} = imm;
      len = (op == OP_LDI || op == OP_J) ? 6 : 2;
      for (int i = 0; i < len; i++) begin
        put_item(KIND_WRB, at, code[i]);
        at = 16'(at + 1);
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] base;
    int pick;
    in_if.valid   <= 1'b0;
    in_if.kind    <= KIND_WRB;
    in_if.address <= '0;
    in_if.data    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: load immediate straddling the top of memory, a deep right shift, two illegal instructions
    set_start_pc(16'hfffe);
    put_item(KIND_WRB, 16'hfffe, {OP_LDI, 4'hf});   // register nibble f means r7
    put_item(KIND_WRB, 16'hffff, 8'h00);
    put_item(KIND_WRB, 16'h0000, 8'h80);
    put_item(KIND_WRB, 16'h0001, 8'h00);
    put_item(KIND_WRB, 16'h0002, 8'h00);
    put_item(KIND_WRB, 16'h0003, 8'h00);
    put_item(KIND_EXEC, 16'hffff, 8'hff);
    put_item(KIND_RDREG, 16'hffff, 8'h00);
    put_item(KIND_RDWORD, 16'hfffe, 8'hff);
    put_item(KIND_RDWORD, 16'h0000, 8'h00);
    put_item(KIND_EXEC, 16'h0000, 8'h00);           // zeros at 4: load immediate into r0
    put_item(KIND_WRB, 16'h000a, {OP_SHF, 4'h7});
    put_item(KIND_WRB, 16'h000b, 8'h81);            // right by 127: sign fill
    put_item(KIND_EXEC, 16'h0000, 8'h00);
    put_item(KIND_RDREG, 16'h0007, 8'h00);
    put_item(KIND_WRB, 16'h000c, {OP_ALU, 4'h8});   // undefined alu function
    put_item(KIND_WRB, 16'h000e, 8'hd0);            // undefined opcode
    put_item(KIND_EXEC, 16'h0000, 8'h00);
    put_item(KIND_EXEC, 16'h0000, 8'h00);
    put_item(KIND_RDREG, 16'h0000, 8'h00);

    // random: short programs from a fresh start address, then run and probe them
    while (beats_in < ItemTarget - 10) begin
      drain();
      if (beats_in < ItemTarget / 3) begin
        send_idle = 21; recv_idle = 71;
      end else if (beats_in < 2 * ItemTarget / 3) begin
        send_idle = 71; recv_idle = 21;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      case ($urandom_range(7))
        0: base = 16'h0000;
        1: base = 16'hffff;
        2: base = 16'($urandom_range(16'hfff0, 16'hffff));
        3: base = 16'($urandom());
        default: base = 16'($urandom_range(255));
      endcase
      set_start_pc(base);
      load_program(base, $urandom_range(3, 8));
      repeat ($urandom_range(10, 18)) begin
        pick = $urandom_range(99);
        if (pick < 60)
          put_item(KIND_EXEC, 16'($urandom()), 8'($urandom()));
        else if (pick < 72)
          put_item(KIND_RDREG, 16'($urandom()), 8'($urandom()));
        else if (pick < 84)
          put_item(KIND_RDWORD, ($urandom_range(1) != 0) ? 16'(base + $urandom_range(15))
                                                         : 16'($urandom()), 8'($urandom()));
        else
          put_item(KIND_WRB, ($urandom_range(3) != 0) ? 16'(base + $urandom_range(31))
                                                      : 16'($urandom()), 8'($urandom()));
      end
    end

    // halt last, since nothing clears it: later executes must leave everything alone
    drain();
    set_start_pc(16'h0200);
    put_item(KIND_WRB, 16'h0200, {OP_SYS, SYS_HALT});
    put_item(KIND_WRB, 16'h0201, 8'h00);
    put_item(KIND_EXEC, 16'h0000, 8'h00);
    put_item(KIND_EXEC, 16'h0000, 8'h00);
    put_item(KIND_RDREG, 16'h0003, 8'h00);
    put_item(KIND_WRB, 16'h0202, 8'h5a);
    put_item(KIND_RDWORD, 16'h0200, 8'h00);

    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
